@@ hdl/dwb_pkg.sv @@
// Shared constants, codes and arithmetic helpers for the displacement warp core.
package dwb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 9;
  localparam int ADDR_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SCALE  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Four steps of a restoring remainder: the partial remainder stays below the divisor.
  function automatic logic [DIM_W-1:0] rem_step4(input logic [DIM_W-1:0] r_in,
                                                 input logic [3:0] bits,
                                                 input logic [DIM_W-1:0] d);
    logic [DIM_W:0] r;
    r = {1'b0, r_in};
    for (int i = 3; i >= 0; i--) begin
      r = {r[DIM_W-1:0], bits[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r[DIM_W-1:0];
  endfunction

  // Rescales the 8-bit position fraction to the interpolation fraction width.
  function automatic logic [FRAC_BITS-1:0] frac_conv(input logic [7:0] f);
    logic [FRAC_BITS+7:0] t;
    t = (FRAC_BITS+8)'(f) << FRAC_BITS;
    return t[FRAC_BITS+7:8];
  endfunction

  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] inv;
    logic [CH_W+FRAC_BITS:0] acc;
    inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
    acc = (CH_W+FRAC_BITS+1)'(a * inv) + (CH_W+FRAC_BITS+1)'(b * f);
    return acc[FRAC_BITS +: CH_W];
  endfunction

endpackage

@@ hdl/dwb_in_if.sv @@
// Input channel of the warp core: pixel loads and warp queries.
interface dwb_in_if import dwb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COLOR_W-1:0] color;
  logic [7:0]         smear;

  modport source (output valid, func, pos_x, pos_y, color, smear, input ready);
  modport sink   (input valid, func, pos_x, pos_y, color, smear, output ready);
endinterface

@@ hdl/dwb_out_if.sv @@
// Output channel of the warp core: interpolated pixels.
interface dwb_out_if import dwb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ hdl/displacement_warp_bilinear_core.sv @@
// Top level of the displacement warp core with bilinear resampling.
//
// Usage: pix_in carries transactions of two kinds. A load (func 0) writes the
// color and smear value of pixel (pos_x, pos_y) and produces no output. A query
// (func 1) returns one interpolated pixel on pix_out. Both stores are undefined
// until loaded; a query may only touch loaded pixels.
// Configuration (width, height, scale) is written through cfg_we, cfg_index and
// cfg_data while no transaction is in flight.
// The core accepts one transaction per cycle while pix_out does not stall,
// using a 13-stage pipeline with duplicated RAMs so that the four smear reads
// of a query happen together, and so do its four color reads. The modulo
// operations run as a chain of restoring remainder stages, four bits per stage.
// Reset clears the pipeline valid bits and loads width 256, height 256 and
// scale 1.0; store contents are kept. When pix_out stalls, each stage holds
// only while the stage after it is occupied, so bubbles fill up before
// pix_in.ready drops.
module displacement_warp_bilinear_core import dwb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data,
  dwb_in_if.sink               pix_in,
  dwb_out_if.source            pix_out
);

  localparam int NSTAGE = 13;

  logic [DIM_W-1:0]          cfg_width;
  logic [DIM_W-1:0]          cfg_height;
  logic signed [SCALE_W-1:0] cfg_scale;

  logic [DIM_W-1:0]          w_eff;
  logic [DIM_W-1:0]          h_eff;
  logic signed [SCALE_W-1:0] s_eff;

  logic [NSTAGE:1] v;
  logic [NSTAGE:1] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIM_W'(MAX_WIDTH);
      cfg_height <= DIM_W'(MAX_HEIGHT);
      cfg_scale  <= SCALE_W'(256);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  cfg_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: cfg_height <= cfg_data[DIM_W-1:0];
        REG_SCALE:  cfg_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width < DIM_W'(2)) w_eff = DIM_W'(2);
    else if (cfg_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = cfg_width;
    if (cfg_height < DIM_W'(2)) h_eff = DIM_W'(2);
    else if (cfg_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = cfg_height;
    s_eff = (cfg_scale == '0) ? SCALE_W'(256) : cfg_scale;
  end

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[NSTAGE] = !v[NSTAGE] || pix_out.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pix_in.ready = en[1];

  // Stage registers. Load data (func, write address, color) ride along up to
  // the color RAM write.
  func_t              s1_func, s2_func, s3_func, s4_func, s5_func;
  func_t              s6_func, s7_func, s8_func, s9_func, s10_func, s11_func;
  logic [ADDR_W-1:0]  s1_wa, s2_wa, s3_wa, s4_wa, s5_wa, s6_wa, s7_wa, s8_wa, s9_wa, s10_wa;
  logic [COLOR_W-1:0] s1_col, s2_col, s3_col, s4_col, s5_col;
  logic [COLOR_W-1:0] s6_col, s7_col, s8_col, s9_col, s10_col;
  logic [7:0]         s1_sm, s2_sm;
  logic [3:0]         s1_lx, s1_ly;
  logic [DIM_W-1:0]   s1_rx, s1_ry;
  logic [COORD_W-1:0] s2_x, s2_y, s3_x, s3_y, s4_x, s4_y;
  logic signed [24:0] s4_prx, s4_pry;
  logic [15:0]        s5_ax, s5_ay, s6_ax, s6_ay, s7_ax, s7_ay, s8_ax, s8_ay;
  logic               s5_nx, s5_ny, s6_nx, s6_ny, s7_nx, s7_ny, s8_nx, s8_ny, s9_nx, s9_ny;
  logic [7:0]         s5_fx, s5_fy, s6_fx, s6_fy, s7_fx, s7_fy, s8_fx, s8_fy, s9_fx, s9_fy;
  logic [DIM_W-1:0]   s6_rx, s6_ry, s7_rx, s7_ry, s8_rx, s8_ry, s9_rx, s9_ry;
  logic [COORD_W-1:0] s10_ix, s10_iy;
  logic [FRAC_BITS-1:0] s10_fx, s10_fy, s11_fx, s11_fy, s12_fy;
  logic [2:0][CH_W-1:0] s12_va, s12_vb;
  logic [CH_W-1:0]    out_red, out_green, out_blue;

  // Combinational values between stages.
  logic [DIM_W-1:0]   x_rem, y_rem;
  logic [COORD_W-1:0] xl, xr, yu, yd, ix1, iy1;
  logic signed [8:0]  dx, dy;
  logic signed [25:0] sum_x, sum_y;
  logic [17:0]        mag_x, mag_y;
  logic [COORD_W-1:0] ix_c, iy_c;
  logic [7:0]         sm_l, sm_r, sm_u, sm_d;
  logic [COLOR_W-1:0] c0, c1, c2, c3;
  logic [2:0][CH_W-1:0] va_c, vb_c;

  always_comb begin
    x_rem = rem_step4(s1_rx, s1_lx, w_eff);
    y_rem = rem_step4(s1_ry, s1_ly, h_eff);
    xl = (s2_x == '0) ? COORD_W'(w_eff - DIM_W'(1)) : s2_x - COORD_W'(1);
    xr = ({1'b0, s2_x} + DIM_W'(1) == w_eff) ? '0 : s2_x + COORD_W'(1);
    yu = (s2_y == '0) ? COORD_W'(h_eff - DIM_W'(1)) : s2_y - COORD_W'(1);
    yd = ({1'b0, s2_y} + DIM_W'(1) == h_eff) ? '0 : s2_y + COORD_W'(1);
    dx = $signed({1'b0, sm_l}) - $signed({1'b0, sm_r});
    dy = $signed({1'b0, sm_u}) - $signed({1'b0, sm_d});
    sum_x = 26'(s4_prx) + $signed({10'd0, s4_x, 8'd0});
    sum_y = 26'(s4_pry) + $signed({10'd0, s4_y, 8'd0});
    mag_x = sum_x[25] ? 18'd0 - sum_x[25:8] : sum_x[25:8];
    mag_y = sum_y[25] ? 18'd0 - sum_y[25:8] : sum_y[25:8];
    // A negative coordinate with a nonzero remainder wraps to the far side.
    ix_c = (s9_nx && s9_rx != '0) ? COORD_W'(w_eff - s9_rx) : s9_rx[COORD_W-1:0];
    iy_c = (s9_ny && s9_ry != '0) ? COORD_W'(h_eff - s9_ry) : s9_ry[COORD_W-1:0];
    ix1 = ({1'b0, s10_ix} + DIM_W'(1) == w_eff) ? '0 : s10_ix + COORD_W'(1);
    iy1 = ({1'b0, s10_iy} + DIM_W'(1) == h_eff) ? '0 : s10_iy + COORD_W'(1);
    for (int c = 0; c < 3; c++) begin
      va_c[c] = lerp(c0[c*CH_W +: CH_W], c1[c*CH_W +: CH_W], s11_fx);
      vb_c[c] = lerp(c2[c*CH_W +: CH_W], c3[c*CH_W +: CH_W], s11_fx);
    end
  end

  // Smear stores: two copies so that all four neighbors are read at once.
  logic sm_we;
  logic col_we;
  assign sm_we  = en[3] && v[2] && (s2_func == FUNC_LOAD);
  assign col_we = en[11] && v[10] && (s10_func == FUNC_LOAD);

  dwb_ram #(.DATA_W(8), .ADDR_W(ADDR_W)) u_smear_h (
    .clk(clk), .we(sm_we), .waddr(s2_wa), .wdata(s2_sm), .re(en[3]),
    .raddr0({s2_y, xl}), .raddr1({s2_y, xr}), .rdata0(sm_l), .rdata1(sm_r)
  );

  dwb_ram #(.DATA_W(8), .ADDR_W(ADDR_W)) u_smear_v (
    .clk(clk), .we(sm_we), .waddr(s2_wa), .wdata(s2_sm), .re(en[3]),
    .raddr0({yu, s2_x}), .raddr1({yd, s2_x}), .rdata0(sm_u), .rdata1(sm_d)
  );

  dwb_ram #(.DATA_W(COLOR_W), .ADDR_W(ADDR_W)) u_color_top (
    .clk(clk), .we(col_we), .waddr(s10_wa), .wdata(s10_col), .re(en[11]),
    .raddr0({s10_iy, s10_ix}), .raddr1({s10_iy, ix1}), .rdata0(c0), .rdata1(c1)
  );

  dwb_ram #(.DATA_W(COLOR_W), .ADDR_W(ADDR_W)) u_color_bot (
    .clk(clk), .we(col_we), .waddr(s10_wa), .wdata(s10_col), .re(en[11]),
    .raddr0({iy1, s10_ix}), .raddr1({iy1, ix1}), .rdata0(c2), .rdata1(c3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= pix_in.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          if (k == NSTAGE - 1) begin
            // Loads leave the pipeline once the color store has been written.
            v[k] <= v[k-1] && (s11_func == FUNC_QUERY);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_func <= func_t'(pix_in.func);
      s1_wa   <= {pix_in.pos_y, pix_in.pos_x};
      s1_col  <= pix_in.color;
      s1_sm   <= pix_in.smear;
      s1_lx   <= pix_in.pos_x[3:0];
      s1_ly   <= pix_in.pos_y[3:0];
      s1_rx   <= rem_step4('0, pix_in.pos_x[7:4], w_eff);
      s1_ry   <= rem_step4('0, pix_in.pos_y[7:4], h_eff);
    end
    if (en[2]) begin
      s2_func <= s1_func;
      s2_wa   <= s1_wa;
      s2_col  <= s1_col;
      s2_sm   <= s1_sm;
      s2_x    <= x_rem[COORD_W-1:0];
      s2_y    <= y_rem[COORD_W-1:0];
    end
    if (en[3]) begin
      s3_func <= s2_func;
      s3_wa   <= s2_wa;
      s3_col  <= s2_col;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
    end
    if (en[4]) begin
      s4_func <= s3_func;
      s4_wa   <= s3_wa;
      s4_col  <= s3_col;
      s4_x    <= s3_x;
      s4_y    <= s3_y;
      s4_prx  <= dx * s_eff;
      s4_pry  <= dy * s_eff;
    end
    if (en[5]) begin
      s5_func <= s4_func;
      s5_wa   <= s4_wa;
      s5_col  <= s4_col;
      s5_ax   <= mag_x[15:0];
      s5_ay   <= mag_y[15:0];
      s5_nx   <= sum_x[25];
      s5_ny   <= sum_y[25];
      s5_fx   <= sum_x[7:0];
      s5_fy   <= sum_y[7:0];
    end
    if (en[6]) begin
      s6_func <= s5_func;
      s6_wa   <= s5_wa;
      s6_col  <= s5_col;
      s6_ax   <= s5_ax;
      s6_ay   <= s5_ay;
      s6_nx   <= s5_nx;
      s6_ny   <= s5_ny;
      s6_fx   <= s5_fx;
      s6_fy   <= s5_fy;
      s6_rx   <= rem_step4('0, s5_ax[15:12], w_eff);
      s6_ry   <= rem_step4('0, s5_ay[15:12], h_eff);
    end
    if (en[7]) begin
      s7_func <= s6_func;
      s7_wa   <= s6_wa;
      s7_col  <= s6_col;
      s7_ax   <= s6_ax;
      s7_ay   <= s6_ay;
      s7_nx   <= s6_nx;
      s7_ny   <= s6_ny;
      s7_fx   <= s6_fx;
      s7_fy   <= s6_fy;
      s7_rx   <= rem_step4(s6_rx, s6_ax[11:8], w_eff);
      s7_ry   <= rem_step4(s6_ry, s6_ay[11:8], h_eff);
    end
    if (en[8]) begin
      s8_func <= s7_func;
      s8_wa   <= s7_wa;
      s8_col  <= s7_col;
      s8_ax   <= s7_ax;
      s8_ay   <= s7_ay;
      s8_nx   <= s7_nx;
      s8_ny   <= s7_ny;
      s8_fx   <= s7_fx;
      s8_fy   <= s7_fy;
      s8_rx   <= rem_step4(s7_rx, s7_ax[7:4], w_eff);
      s8_ry   <= rem_step4(s7_ry, s7_ay[7:4], h_eff);
    end
    if (en[9]) begin
      s9_func <= s8_func;
      s9_wa   <= s8_wa;
      s9_col  <= s8_col;
      s9_nx   <= s8_nx;
      s9_ny   <= s8_ny;
      s9_fx   <= s8_fx;
      s9_fy   <= s8_fy;
      s9_rx   <= rem_step4(s8_rx, s8_ax[3:0], w_eff);
      s9_ry   <= rem_step4(s8_ry, s8_ay[3:0], h_eff);
    end
    if (en[10]) begin
      s10_func <= s9_func;
      s10_wa   <= s9_wa;
      s10_col  <= s9_col;
      s10_ix   <= ix_c;
      s10_iy   <= iy_c;
      s10_fx   <= frac_conv(s9_fx);
      s10_fy   <= frac_conv(s9_fy);
    end
    if (en[11]) begin
      s11_func <= s10_func;
      s11_fx   <= s10_fx;
      s11_fy   <= s10_fy;
    end
    if (en[12]) begin
      s12_va <= va_c;
      s12_vb <= vb_c;
      s12_fy <= s11_fy;
    end
    if (en[13]) begin
      out_red   <= lerp(s12_va[0], s12_vb[0], s12_fy);
      out_green <= lerp(s12_va[1], s12_vb[1], s12_fy);
      out_blue  <= lerp(s12_va[2], s12_vb[2], s12_fy);
    end
  end

  assign pix_out.valid = v[NSTAGE];
  assign pix_out.red   = out_red;
  assign pix_out.green = out_green;
  assign pix_out.blue  = out_blue;

`ifndef SYNTHESIS
  a_wrapped_pos: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> ({1'b0, s2_x} < w_eff && {1'b0, s2_y} < h_eff))
    else $error("wrapped query position outside the image");

  // Loads may see unloaded smear neighbors, so only queries are checked here.
  a_remainder: assert property (@(posedge clk) disable iff (rst)
    (v[9] && s9_func == FUNC_QUERY) |-> (s9_rx < w_eff && s9_ry < h_eff))
    else $error("displaced remainder not below the image size");

  a_sample_pos: assert property (@(posedge clk) disable iff (rst)
    (v[10] && s10_func == FUNC_QUERY) |->
      ({1'b0, s10_ix} < w_eff && {1'b0, s10_iy} < h_eff))
    else $error("sample position outside the image");

  a_no_load_out: assert property (@(posedge clk) disable iff (rst)
    (v[11] && en[12] && s11_func == FUNC_LOAD) |=> !v[12])
    else $error("load transaction reached the output stages");
`endif

endmodule

@@ hdl/dwb_ram.sv @@
// Simple dual-read RAM with one write port and registered read data.
module dwb_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ tb/sv/tb_displacement_warp_bilinear_core.sv @@
// Self-checking testbench for the displacement warp core with bilinear resampling.
`timescale 1ns / 1ps

module tb_displacement_warp_bilinear_core;
  import dwb_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PER_PHASE = 50;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0] cfg_data;

  dwb_in_if pix_in ();
  dwb_out_if pix_out ();

  displacement_warp_bilinear_core u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_in(pix_in.sink),
    .pix_out(pix_out.source)
  );

  int errors;
  longint cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_stall;
  bit loaded [0:65535];

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at cycle %0d: %s", cycles, msg);
  endtask

  class warp_scoreboard;
    logic [23:0] color_mem [0:65535];
    logic [7:0] smear_mem [0:65535];
    bit [8:0] width_reg;
    bit [8:0] height_reg;
    bit [15:0] scale_reg;
    pixel_t expected_q[$];
    int queries;
    int results;

    function new();
      width_reg = 256;
      height_reg = 256;
      scale_reg = 256;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] d);
      case (idx)
        REG_WIDTH: width_reg = d[8:0];
        REG_HEIGHT: height_reg = d[8:0];
        REG_SCALE: scale_reg = d;
        default: ;
      endcase
    endfunction

    function int dim_in_use(bit [8:0] v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function int blend(int a, int b, int f);
      return (a * (256 - f) + b * f) >>> 8;
    endfunction

    function void note_input(func_t f, int px, int py, logic [23:0] c, logic [7:0] sm);
      int w, h, x, y, ix, iy, ix1, iy1, fx, fy, ch, va, vb;
      longint s, ddx, ddy, sx, sy;
      logic [23:0] p0, p1, p2, p3;
      int res [3];
      pixel_t e;
      if (f == FUNC_LOAD) begin
        color_mem[py * MAX_WIDTH + px] = c;
        smear_mem[py * MAX_WIDTH + px] = sm;
        return;
      end
      w = dim_in_use(width_reg, MAX_WIDTH);
      h = dim_in_use(height_reg, MAX_HEIGHT);
      x = px % w;
      y = py % h;
      s = longint'($signed(scale_reg));
      if (s == 0) s = 256;
      ddx = longint'(smear_mem[y * MAX_WIDTH + (x + w - 1) % w])
          - longint'(smear_mem[y * MAX_WIDTH + (x + 1) % w]);
      ddy = longint'(smear_mem[((y + h - 1) % h) * MAX_WIDTH + x])
          - longint'(smear_mem[((y + 1) % h) * MAX_WIDTH + x]);
      sx = (longint'(x) * 256 + ddx * s) % (longint'(w) * 256);
      if (sx < 0) sx += longint'(w) * 256;
      sy = (longint'(y) * 256 + ddy * s) % (longint'(h) * 256);
      if (sy < 0) sy += longint'(h) * 256;
      ix = int'(sx >>> 8);
      iy = int'(sy >>> 8);
      fx = int'(sx & 255);
      fy = int'(sy & 255);
      ix1 = (ix + 1) % w;
      iy1 = (iy + 1) % h;
      p0 = color_mem[iy * MAX_WIDTH + ix];
      p1 = color_mem[iy * MAX_WIDTH + ix1];
      p2 = color_mem[iy1 * MAX_WIDTH + ix];
      p3 = color_mem[iy1 * MAX_WIDTH + ix1];
      for (ch = 0; ch < 3; ch++) begin
        va = blend(p0[ch*8 +: 8], p1[ch*8 +: 8], fx);
        vb = blend(p2[ch*8 +: 8], p3[ch*8 +: 8], fx);
        res[ch] = blend(va, vb, fy) & 255;
      end
      e.red = 8'(res[0]);
      e.green = 8'(res[1]);
      e.blue = 8'(res[2]);
      expected_q.push_back(e);
      queries++;
    endfunction

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t e;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel r=%0h g=%0h b=%0h", r, g, b));
        return;
      end
      e = expected_q.pop_front();
      if (r !== e.red) report_mismatch($sformatf("red %0h, want %0h", r, e.red));
      if (g !== e.green) report_mismatch($sformatf("green %0h, want %0h", g, e.green));
      if (b !== e.blue) report_mismatch($sformatf("blue %0h, want %0h", b, e.blue));
    endtask
  endclass

  warp_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver side: while rx_idle_on is set, stall a random number of cycles after every transaction.
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      sb.check_result(pix_out.red, pix_out.green, pix_out.blue);
      rx_stall = rx_idle_on ? $urandom_range(0, 18) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_stall > 0) begin
      pix_out.ready = 1'b0;
      rx_stall--;
    end else begin
      pix_out.ready = 1'b1;
    end
  end

  task automatic send_item(func_t f, int px, int py, logic [23:0] c, logic [7:0] sm);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid = 1'b1;
    pix_in.func = f;
    pix_in.pos_x = 8'(px);
    pix_in.pos_y = 8'(py);
    pix_in.color = c;
    pix_in.smear = sm;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_input(f, px, py, c, sm);
    if (f == FUNC_LOAD) loaded[py * MAX_WIDTH + px] = 1'b1;
    @(negedge clk);
  endtask

  task automatic drain();
    pix_in.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Every pixel of the active image must hold data before any query can touch it.
  task automatic fill_image(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!loaded[y * MAX_WIDTH + x])
          send_item(FUNC_LOAD, x, y, 24'($urandom_range(0, 24'hffffff)),
                    8'($urandom_range(0, 255)));
  endtask

  task automatic random_traffic(int w, int h, int count);
    int x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        send_item(FUNC_QUERY, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom),
                  8'($urandom));
      end else begin
        x = $urandom_range(0, 1) ? $urandom_range(0, w - 1) : $urandom_range(0, 255);
        y = $urandom_range(0, 1) ? $urandom_range(0, h - 1) : $urandom_range(0, 255);
        send_item(FUNC_LOAD, x, y, 24'($urandom_range(0, 24'hffffff)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int wd [8] = '{4, 0, 256, 2, 300, 2, 16, 33};
    int hd [8] = '{4, 1, 2, 256, 2, 511, 4, 7};
    int sd [8] = '{256, 0, 16'h8000, 16'h7fff, 0, 16'hff00, 0, 128};
    int w, h;
    errors = 0;
    cycles = 0;
    rx_stall = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.func = FUNC_LOAD;
    pix_in.pos_x = '0;
    pix_in.pos_y = '0;
    pix_in.color = '0;
    pix_in.smear = '0;
    pix_out.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < 8; p++) begin
      drain();
      // Phases 4 and 6 pick their gain at random.
      if (p == 4 || p == 6) sd[p] = $urandom_range(0, 16'hffff);
      write_cfg(REG_WIDTH, 16'(wd[p]));
      write_cfg(REG_HEIGHT, 16'(hd[p]));
      write_cfg(REG_SCALE, 16'(sd[p]));
      w = sb.dim_in_use(9'(wd[p]), MAX_WIDTH);
      h = sb.dim_in_use(9'(hd[p]), MAX_HEIGHT);
      tx_idle_on = (p % 3) != 0;
      rx_idle_on = (p % 4) != 1;
      fill_image(w, h);
      if (p == 0) begin
        send_item(FUNC_LOAD, 0, 0, 24'h000000, 8'h00);
        send_item(FUNC_LOAD, 255, 255, 24'hffffff, 8'hff);
        send_item(FUNC_LOAD, 3, 3, 24'hffffff, 8'hff);
        send_item(FUNC_LOAD, 1, 2, 24'h000000, 8'h00);
        send_item(FUNC_LOAD, 3, 0, 24'h00ff00, 8'hff);
        send_item(FUNC_QUERY, 0, 0, 24'hffffff, 8'hff);
        send_item(FUNC_QUERY, 3, 3, 24'h0, 8'h0);
        send_item(FUNC_QUERY, 255, 255, 24'h0, 8'h0);
        send_item(FUNC_QUERY, 4, 4, 24'h0, 8'h0);
        send_item(FUNC_QUERY, 0, 3, 24'h0, 8'h0);
        // Hold off until the pipeline is empty before going on.
        drain();
        send_item(FUNC_QUERY, 2, 1, 24'h0, 8'h0);
      end
      random_traffic(w, h, RANDOM_PER_PHASE);
    end

    drain();
    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      report_mismatch("expected pixel never arrived");
    end
    $display("Run covered %0d queries and %0d results over 8 image sizes and gains,",
             sb.queries, sb.results);
    $display("including 2-pixel and 256-pixel edges, zero and extreme gains.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dwb_pkg.sv
hdl/dwb_in_if.sv
hdl/dwb_out_if.sv
hdl/dwb_ram.sv
hdl/displacement_warp_bilinear_core.sv
tb/sv/tb_displacement_warp_bilinear_core.sv
